[design/hsv2rgb_pkg.sv]
// ============================================================================
// hsv2rgb_pkg
// Shared constants, sector codes and inter-stage bundles for the HSV to RGB
// converter pipeline.
// ============================================================================
package hsv2rgb_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned PROD_W = 2 * CHAN_W;

    // Width of one hue sector and the full-scale channel value
    localparam logic [CHAN_W-1:0] SECTOR_WIDTH = 8'd43;
    localparam logic [CHAN_W-1:0] FULL_SCALE   = 8'd255;
    localparam logic [CHAN_W-1:0] OFFSET_SCALE = 8'd6;

    // Hue sectors, named by the primaries they span
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    // Stage 1 -> stage 2
    typedef struct packed {
        sector_t           sector;
        logic              gray;    // saturation is zero
        logic [CHAN_W-1:0] off;     // scaled offset inside the sector
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        logic [CHAN_W-1:0] p;
    } split_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        sector_t           sector;
        logic              gray;
        logic [CHAN_W-1:0] val;
        logic [CHAN_W-1:0] p;
        logic [CHAN_W-1:0] sf;      // (s * f) >> 8
        logic [CHAN_W-1:0] sg;      // (s * (255 - f)) >> 8
    } shade_t;

    // Output beat
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

endpackage

[design/hsv2rgb_split.sv]
// ============================================================================
// hsv2rgb_split
// Stage 1: hue sector lookup, scaled sector offset and the p level product.
// ============================================================================
module hsv2rgb_split
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]   hue,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]   saturation,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]   brightness,
    output logic                             out_valid,
    input  logic                             out_ready,
    output hsv2rgb_pkg::split_t              out_data
);

    logic                           valid_reg;
    hsv2rgb_pkg::split_t            data_reg;
    hsv2rgb_pkg::split_t            data_next;
    hsv2rgb_pkg::sector_t           sector;
    logic [hsv2rgb_pkg::CHAN_W-1:0] base;
    logic [hsv2rgb_pkg::CHAN_W-1:0] rem;
    logic [hsv2rgb_pkg::CHAN_W-1:0] off;
    logic [hsv2rgb_pkg::PROD_W-1:0] p_prod;

    // Sector by comparison against the sector boundaries
    always_comb
    begin
        priority if (hue < hsv2rgb_pkg::SECTOR_WIDTH)
        begin
            sector = hsv2rgb_pkg::SEC_R_Y;
            base   = 8'd0;
        end
        else if (hue < 8'(2 * hsv2rgb_pkg::SECTOR_WIDTH))
        begin
            sector = hsv2rgb_pkg::SEC_Y_G;
            base   = hsv2rgb_pkg::SECTOR_WIDTH;
        end
        else if (hue < 8'(3 * hsv2rgb_pkg::SECTOR_WIDTH))
        begin
            sector = hsv2rgb_pkg::SEC_G_C;
            base   = 8'(2 * hsv2rgb_pkg::SECTOR_WIDTH);
        end
        else if (hue < 8'(4 * hsv2rgb_pkg::SECTOR_WIDTH))
        begin
            sector = hsv2rgb_pkg::SEC_C_B;
            base   = 8'(3 * hsv2rgb_pkg::SECTOR_WIDTH);
        end
        else if (hue < 8'(5 * hsv2rgb_pkg::SECTOR_WIDTH))
        begin
            sector = hsv2rgb_pkg::SEC_B_M;
            base   = 8'(4 * hsv2rgb_pkg::SECTOR_WIDTH);
        end
        else
        begin
            sector = hsv2rgb_pkg::SEC_M_R;
            base   = 8'(5 * hsv2rgb_pkg::SECTOR_WIDTH);
        end
    end

    // Offset inside the sector, at most 42, scaled by six (fits in 8 bits)
    assign rem    = hue - base;
    assign off    = 8'(rem * hsv2rgb_pkg::OFFSET_SCALE);
    assign p_prod = {8'd0, brightness} * {8'd0, 8'(hsv2rgb_pkg::FULL_SCALE - saturation)};

    always_comb
    begin
        data_next.sector = sector;
        data_next.gray   = (saturation == 8'd0);
        data_next.off    = off;
        data_next.sat    = saturation;
        data_next.val    = brightness;
        data_next.p      = p_prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::CHAN_W];
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/hsv2rgb_scale.sv]
// ============================================================================
// hsv2rgb_scale
// Stage 2: saturation times offset and saturation times inverted offset.
// ============================================================================
module hsv2rgb_scale
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsv2rgb_pkg::split_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsv2rgb_pkg::shade_t   out_data
);

    logic                           valid_reg;
    hsv2rgb_pkg::shade_t            data_reg;
    hsv2rgb_pkg::shade_t            data_next;
    logic [hsv2rgb_pkg::PROD_W-1:0] sf_prod;
    logic [hsv2rgb_pkg::PROD_W-1:0] sg_prod;

    // Two independent 8x8 products
    assign sf_prod = {8'd0, in_data.sat} * {8'd0, in_data.off};
    assign sg_prod = {8'd0, in_data.sat} * {8'd0, 8'(hsv2rgb_pkg::FULL_SCALE - in_data.off)};

    always_comb
    begin
        data_next.sector = in_data.sector;
        data_next.gray   = in_data.gray;
        data_next.val    = in_data.val;
        data_next.p      = in_data.p;
        data_next.sf     = sf_prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::CHAN_W];
        data_next.sg     = sg_prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::CHAN_W];
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/hsv2rgb_route.sv]
// ============================================================================
// hsv2rgb_route
// Stage 3: q and t level products, per-sector channel routing, gray override
// and the output register.
// ============================================================================
module hsv2rgb_route
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsv2rgb_pkg::shade_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsv2rgb_pkg::rgb_t     out_data
);

    logic                           valid_reg;
    hsv2rgb_pkg::rgb_t              data_reg;
    hsv2rgb_pkg::rgb_t              data_next;
    logic [hsv2rgb_pkg::PROD_W-1:0] q_prod;
    logic [hsv2rgb_pkg::PROD_W-1:0] t_prod;
    logic [hsv2rgb_pkg::CHAN_W-1:0] q;
    logic [hsv2rgb_pkg::CHAN_W-1:0] t;
    logic [hsv2rgb_pkg::CHAN_W-1:0] v;
    logic [hsv2rgb_pkg::CHAN_W-1:0] p;

    assign q_prod = {8'd0, in_data.val} * {8'd0, 8'(hsv2rgb_pkg::FULL_SCALE - in_data.sf)};
    assign t_prod = {8'd0, in_data.val} * {8'd0, 8'(hsv2rgb_pkg::FULL_SCALE - in_data.sg)};
    assign q      = q_prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::CHAN_W];
    assign t      = t_prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::CHAN_W];
    assign v      = in_data.val;
    assign p      = in_data.p;

    // Channel routing; gray pixels bypass it, black gray turns white
    always_comb
    begin
        if (in_data.gray)
        begin
            if (v == 8'd0)
            begin
                data_next.red   = hsv2rgb_pkg::FULL_SCALE;
                data_next.green = hsv2rgb_pkg::FULL_SCALE;
                data_next.blue  = hsv2rgb_pkg::FULL_SCALE;
            end
            else
            begin
                data_next.red   = v;
                data_next.green = v;
                data_next.blue  = v;
            end
        end
        else
        begin
            unique case (in_data.sector)
                hsv2rgb_pkg::SEC_R_Y:
                begin
                    data_next.red   = v;
                    data_next.green = t;
                    data_next.blue  = p;
                end
                hsv2rgb_pkg::SEC_Y_G:
                begin
                    data_next.red   = q;
                    data_next.green = v;
                    data_next.blue  = p;
                end
                hsv2rgb_pkg::SEC_G_C:
                begin
                    data_next.red   = p;
                    data_next.green = v;
                    data_next.blue  = t;
                end
                hsv2rgb_pkg::SEC_C_B:
                begin
                    data_next.red   = p;
                    data_next.green = q;
                    data_next.blue  = v;
                end
                hsv2rgb_pkg::SEC_B_M:
                begin
                    data_next.red   = t;
                    data_next.green = p;
                    data_next.blue  = v;
                end
                default:
                begin
                    data_next.red   = v;
                    data_next.green = p;
                    data_next.blue  = q;
                end
            endcase
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef SYNTH
    // Stage only refuses a beat while holding one
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg)
        else $error("route stage stalled while empty");

    // Black gray input becomes white
    a_gray_black: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid && in_data.gray && in_data.val == 8'd0)
        |=> (data_reg.red == hsv2rgb_pkg::FULL_SCALE
             && data_reg.green == hsv2rgb_pkg::FULL_SCALE
             && data_reg.blue == hsv2rgb_pkg::FULL_SCALE))
        else $error("black gray pixel not white");

    // Gray input gives equal channels
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid && in_data.gray)
        |=> (data_reg.red == data_reg.green && data_reg.green == data_reg.blue))
        else $error("gray pixel with unequal channels");

    // Red-yellow sector keeps brightness on red
    a_sector0_red: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid && !in_data.gray && in_data.sector == hsv2rgb_pkg::SEC_R_Y)
        |=> (data_reg.red == $past(in_data.val)))
        else $error("red channel not brightness in first sector");
`endif

endmodule

[design/hsv_to_rgb_converter.sv]
// ============================================================================
// hsv_to_rgb_converter
// Integer six-sector HSV to RGB pixel converter, three-stage pipeline.
// ============================================================================
// Usage:
//   Slave stream s_* carries one HSV pixel per beat; master stream m_*
//   carries the matching RGB pixel. Both use tvalid/tready; a beat moves
//   when both are high. Pixels leave in the order they arrive.
//   Pipeline: an accepted pixel is registered in each stage in turn (sector/offset
//   and p product, s*f and s*(255-f) products, q/t products with channel
//   routing into the output register) before it is presented on m_tvalid
//   and can leave.
//   Throughput: one pixel per clock while m_tready is high; each stage holds
//   one 8x8 multiply level; a stage register not stalled takes a new beat each cycle.
//   Stall: while m_tready is low, the output register holds its pixel and
//   upstream stages keep filling until all three are occupied; only then
//   does s_tready drop. Nothing is lost or repeated.
//   Reset: rst_n clears all stage valid bits; the block is empty and ready
//   once reset is released. There is no configuration.
// ============================================================================
module hsv_to_rgb_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] hue, [15:8] saturation, [23:16] brightness
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    logic                v1;
    logic                r2;
    hsv2rgb_pkg::split_t d1;
    logic                v2;
    logic                r3;
    hsv2rgb_pkg::shade_t d2;
    hsv2rgb_pkg::rgb_t   rgb;

    hsv2rgb_split u_split
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[7:0]),
        .saturation (s_tdata[15:8]),
        .brightness (s_tdata[23:16]),
        .out_valid  (v1),
        .out_ready  (r2),
        .out_data   (d1)
    );

    hsv2rgb_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r2),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r3),
        .out_data  (d2)
    );

    hsv2rgb_route u_route
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r3),
        .in_data   (d2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb)
    );

    assign m_tdata = {rgb.blue, rgb.green, rgb.red};

endmodule
